[hw/rtl/slcd_pkg.sv]
package slcd_pkg;

  localparam int SLCD_BUF_DEPTH  = 128;
  localparam int SLCD_ADDR_W     = $clog2(SLCD_BUF_DEPTH);
  localparam int SLCD_FILL_W     = SLCD_ADDR_W + 1;
  localparam int SLCD_MAX_FRAME  = 128;
  localparam int SLCD_MIN_FRAME  = 4;
  localparam int SLCD_HDR_LEN    = 3;
  localparam int SLCD_WORD_BYTES = 8;
  localparam logic [7:0] SLCD_START_RESET = 8'h55;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ADDR_RD,
    ST_ADDR_CAP,
    ST_LEN_RD,
    ST_LEN_CHK,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_PAY_RD,
    ST_PAY_ACC,
    ST_PAY_OUT
  } state_t;

endpackage

[hw/rtl/slcd_byte_if.sv]
interface slcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/slcd_cfg_if.sv]
interface slcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_byte;

  modport source (output valid, output start_byte, input ready);
  modport sink (input valid, input start_byte, output ready);
endinterface

[hw/rtl/slcd_word_if.sv]
interface slcd_word_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_address;
  logic [63:0] payload_word;
  logic [3:0]  byte_count;
  logic        frame_last;

  modport source (output valid, output frame_address, output payload_word,
                  output byte_count, output frame_last, input ready);
  modport sink (input valid, input frame_address, input payload_word,
                input byte_count, input frame_last, output ready);
endinterface

[hw/rtl/slcd_ram.sv]
module slcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/start_length_checksum_deframer.sv]
// Channel  Direction  Carries
// -------  ---------  ---------------------------------------------------
// rx       in         rx_byte, one received serial byte per transaction
// cfg      in         start_byte, the frame start marker (always ready)
// frame    out        frame_address, payload_word, byte_count, frame_last
//
// rx is ready only while the parser is idle. The buffer is a single-port-read
// RAM, so every byte examined, in a search, the header, the checksum or the
// payload, takes a read step and then a step that uses the data; emitting a
// frame adds one output step per word. Resyncs repeat searches.
// Reset is synchronous; the buffer contents are not cleared, only the count and head.
// A stalled frame channel holds the parser in its emit step; rx keeps waiting.
module start_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int MAX_FRAME = SLCD_MAX_FRAME
) (
  input  logic        clk,
  input  logic        rst,
  slcd_byte_if.sink   rx,
  slcd_cfg_if.sink    cfg,
  slcd_word_if.source frame
);

  state_t state, state_next;

  logic [SLCD_ADDR_W-1:0] head, head_next;
  logic [SLCD_FILL_W-1:0] fill, fill_next;
  logic [SLCD_FILL_W-1:0] idx, idx_next;
  logic [7:0]             len, len_next;
  logic [7:0]             addr_q, addr_q_next;
  logic [7:0]             sum, sum_next;
  logic [63:0]            word, word_next;
  logic [3:0]             wcnt, wcnt_next;
  logic                   last_q, last_q_next;
  logic [7:0]             start_byte;

  logic                   out_valid;
  logic [7:0]             out_addr;
  logic [63:0]            out_word;
  logic [3:0]             out_cnt;
  logic                   out_last;
  logic                   out_load;

  logic                   wr_en;
  logic [SLCD_ADDR_W-1:0] wr_addr;
  logic [SLCD_ADDR_W-1:0] rd_addr;
  logic [7:0]             rd_data;
  logic [SLCD_FILL_W-1:0] fill_left;
  logic [7:0]             sum_new;
  logic                   len_bad;

  slcd_ram #(
    .WIDTH(8),
    .DEPTH(SLCD_BUF_DEPTH)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(rx.rx_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rx.ready  = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign wr_en     = rx.valid && rx.ready;
  // With a full buffer the slot past the last byte is the oldest one, at head.
  assign wr_addr   = head + fill[SLCD_ADDR_W-1:0];
  assign rd_addr   = head + idx[SLCD_ADDR_W-1:0];
  assign fill_left = fill - idx;
  assign sum_new   = sum + rd_data;
  assign len_bad   = (rd_data < 8'(SLCD_MIN_FRAME)) || (32'(rd_data) > MAX_FRAME)
                     || (rd_data > 8'(SLCD_BUF_DEPTH));

  assign frame.valid         = out_valid;
  assign frame.frame_address = out_addr;
  assign frame.payload_word  = out_word;
  assign frame.byte_count    = out_cnt;
  assign frame.frame_last    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      fill       <= '0;
      out_valid  <= 1'b0;
      start_byte <= SLCD_START_RESET;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      if (cfg.valid) begin
        start_byte <= cfg.start_byte;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    len    <= len_next;
    addr_q <= addr_q_next;
    sum    <= sum_next;
    word   <= word_next;
    wcnt   <= wcnt_next;
    last_q <= last_q_next;
    if (out_load) begin
      out_addr <= addr_q;
      out_word <= word;
      out_cnt  <= wcnt;
      out_last <= last_q;
    end
  end

  always_comb begin
    state_next  = state;
    head_next   = head;
    fill_next   = fill;
    idx_next    = idx;
    len_next    = len;
    addr_q_next = addr_q;
    sum_next    = sum;
    word_next   = word;
    wcnt_next   = wcnt;
    last_q_next = last_q;
    out_load    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (rx.valid) begin
          if (fill == SLCD_FILL_W'(SLCD_BUF_DEPTH)) begin
            head_next = head + 1'b1;
          end else begin
            fill_next = fill + 1'b1;
          end
          idx_next   = '0;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (idx >= fill) begin
          // No start byte anywhere: everything buffered is discarded.
          fill_next  = '0;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (rd_data == start_byte) begin
          head_next = head + idx[SLCD_ADDR_W-1:0];
          fill_next = fill_left;
          if (fill_left < SLCD_FILL_W'(SLCD_HDR_LEN)) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = SLCD_FILL_W'(1);
            state_next = ST_ADDR_RD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_ADDR_RD: begin
        state_next = ST_ADDR_CAP;
      end
      ST_ADDR_CAP: begin
        addr_q_next = rd_data;
        idx_next    = SLCD_FILL_W'(2);
        state_next  = ST_LEN_RD;
      end
      ST_LEN_RD: begin
        state_next = ST_LEN_CHK;
      end
      ST_LEN_CHK: begin
        len_next = rd_data;
        if (len_bad) begin
          idx_next   = SLCD_FILL_W'(1);
          state_next = ST_SCAN_RD;
        end else if (fill < SLCD_FILL_W'(rd_data)) begin
          state_next = ST_IDLE;
        end else begin
          sum_next   = '0;
          idx_next   = '0;
          state_next = ST_SUM_RD;
        end
      end
      ST_SUM_RD: begin
        state_next = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        sum_next = sum_new;
        // A good frame sums to zero including its checksum byte.
        if (idx == SLCD_FILL_W'(len - 8'd1)) begin
          if (sum_new == 8'd0) begin
            word_next = '0;
            wcnt_next = '0;
            if (len == 8'(SLCD_MIN_FRAME)) begin
              last_q_next = 1'b1;
              state_next  = ST_PAY_OUT;
            end else begin
              idx_next   = SLCD_FILL_W'(SLCD_HDR_LEN);
              state_next = ST_PAY_RD;
            end
          end else begin
            idx_next   = SLCD_FILL_W'(1);
            state_next = ST_SCAN_RD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SUM_RD;
        end
      end
      ST_PAY_RD: begin
        state_next = ST_PAY_ACC;
      end
      ST_PAY_ACC: begin
        word_next[{wcnt[2:0], 3'b000} +: 8] = rd_data;
        wcnt_next = wcnt + 1'b1;
        if (idx == SLCD_FILL_W'(len - 8'd2)) begin
          last_q_next = 1'b1;
          state_next  = ST_PAY_OUT;
        end else if (wcnt == 4'(SLCD_WORD_BYTES - 1)) begin
          last_q_next = 1'b0;
          state_next  = ST_PAY_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_PAY_RD;
        end
      end
      ST_PAY_OUT: begin
        if (!out_valid || frame.ready) begin
          out_load = 1'b1;
          if (last_q) begin
            head_next  = head + len[SLCD_ADDR_W-1:0];
            fill_next  = fill - SLCD_FILL_W'(len);
            idx_next   = '0;
            state_next = ST_SCAN_RD;
          end else begin
            idx_next   = idx + 1'b1;
            word_next  = '0;
            wcnt_next  = '0;
            state_next = ST_PAY_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/slcd_checker.sv]
module slcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  frame_address,
  input logic [63:0] payload_word,
  input logic [3:0]  byte_count,
  input logic        frame_last
);

  // A result word that is offered stays offered until it is taken.
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("frame valid dropped before the transaction completed");

  a_payload_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(payload_word) && $stable(frame_address)
                                && $stable(byte_count) && $stable(frame_last))
    else $error("frame payload changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 4'd8)
    else $error("byte_count above eight");

  // Only the final word of a frame may be short.
  a_full_middle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> byte_count == 4'd8)
    else $error("short word that is not the last of its frame");

  a_empty_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd0 |-> frame_last && payload_word == 64'd0)
    else $error("empty payload word malformed");

endmodule

bind start_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (frame.valid),
  .out_ready    (frame.ready),
  .frame_address(frame.frame_address),
  .payload_word (frame.payload_word),
  .byte_count   (frame.byte_count),
  .frame_last   (frame.frame_last)
);
